[rtl/core/rkf_pkg.sv]
// ----------------------------------------------------------------------------
// rkf_pkg
// shared types and constants of the image block framer
// ----------------------------------------------------------------------------
package rkf_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int HDR_CNT_W    = 3;
    localparam int LEN_W        = 9;
    localparam int SLOTS        = 6;
    localparam int SLOT_W       = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    localparam logic [7:0] BYTE_HEADER_TAG   = 8'h47;
    localparam logic [7:0] BYTE_BLOCK_END    = 8'h41;
    localparam logic [7:0] BYTE_BLOCK_OPEN   = 8'h4F;
    localparam logic [7:0] BYTE_STATUS_OK    = 8'h44;
    localparam logic [7:0] BYTE_STATUS_SHORT = 8'h02;

    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    typedef enum logic [1:0] {
        CMD_SHORT,
        CMD_HEADER,
        CMD_PAYLOAD
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [7:0]       data;
        logic [7:0]       aux;
        logic [LEN_W-1:0] len;
        logic             open;
        logic             close;
        logic             fin;
    } cmd_t;

endpackage

[rtl/core/rkf_in_if.sv]
// ----------------------------------------------------------------------------
// rkf_in_if
// image byte request channel
// ----------------------------------------------------------------------------
interface rkf_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       starts_image;

    modport source (output valid, output image_byte, output starts_image, input ready);
    modport sink (input valid, input image_byte, input starts_image, output ready);

endinterface

[rtl/core/rkf_out_if.sv]
// ----------------------------------------------------------------------------
// rkf_out_if
// host byte request channel
// ----------------------------------------------------------------------------
interface rkf_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output byte_kind, output last_of_run,
                    input ready);
    modport sink (input valid, input out_byte, input byte_kind, input last_of_run,
                  output ready);

endinterface

[rtl/core/rkf_front.sv]
// ----------------------------------------------------------------------------
// rkf_front
// accepts image bytes, tracks header and block state, issues burst commands
// ----------------------------------------------------------------------------
module rkf_front #(
    parameter int BLOCK_BYTES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_data,
    rkf_in_if.sink        image,
    input  logic          q_full,
    output logic          push,
    output rkf_pkg::cmd_t push_cmd
);
    import rkf_pkg::*;

    localparam int BR_W = $clog2(BLOCK_BYTES + 1);

    logic [15:0]          image_length_reg;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]          pr_reg, pr_next;
    logic [BR_W-1:0]      br_reg, br_next;
    logic                 finished_reg, finished_next;
    logic [7:0]           hs_reg [0:HEADER_BYTES-1];

    logic                 accept;
    logic                 hs_we;
    logic [1:0]           hs_idx;
    logic [HDR_CNT_W-1:0] hdr_eff;
    logic                 fin_eff;
    logic [15:0]          load_addr, end_addr, span, avail, p_len;
    logic [BR_W-1:0]      blk_len, br_base;
    logic                 blk_open;

    assign image.ready = !q_full;
    assign accept      = image.valid && image.ready;

    assign load_addr = {hs_reg[0], hs_reg[1]};
    assign end_addr  = {hs_reg[2], image.image_byte};
    assign span      = end_addr - load_addr + 16'd1;
    assign avail     = image_length_reg - 16'(HEADER_BYTES);

    always_comb
    begin
        if (image_length_reg < 16'(HEADER_BYTES))
            p_len = 16'd0;
        else if (span > avail)
            p_len = avail;
        else
            p_len = span;
    end

    assign blk_open = (br_reg == '0);
    assign blk_len  = (pr_reg > 16'(BLOCK_BYTES)) ? BR_W'(BLOCK_BYTES) : pr_reg[BR_W-1:0];
    assign br_base  = blk_open ? blk_len : br_reg;

    always_comb
    begin
        hdr_cnt_next  = hdr_cnt_reg;
        pr_next       = pr_reg;
        br_next       = br_reg;
        finished_next = finished_reg;
        push          = 1'b0;
        push_cmd      = '{op: CMD_SHORT, data: '0, aux: '0, len: '0,
                          open: 1'b0, close: 1'b0, fin: 1'b0};
        hs_we         = 1'b0;
        hs_idx        = '0;
        hdr_eff       = image.starts_image ? '0 : hdr_cnt_reg;
        fin_eff       = image.starts_image ? 1'b0 : finished_reg;
        if (accept)
        begin
            hdr_cnt_next  = hdr_eff;
            finished_next = fin_eff;
            if (image.starts_image && image_length_reg < 16'(HEADER_BYTES))
            begin
                push          = 1'b1;
                push_cmd.op   = CMD_SHORT;
                push_cmd.fin  = 1'b1;
                finished_next = 1'b1;
            end
            else if (!fin_eff)
            begin
                if (hdr_eff != HDR_CNT_W'(HEADER_BYTES))
                begin
                    hs_we        = 1'b1;
                    hs_idx       = hdr_eff[1:0];
                    hdr_cnt_next = hdr_eff + 1'b1;
                    if (hdr_eff == HDR_CNT_W'(HEADER_BYTES - 1))
                    begin
                        push          = 1'b1;
                        push_cmd.op   = CMD_HEADER;
                        push_cmd.data = hs_reg[1];
                        push_cmd.aux  = hs_reg[0];
                        push_cmd.fin  = (p_len == 16'd0);
                        pr_next       = p_len;
                        br_next       = '0;
                        finished_next = (p_len == 16'd0);
                    end
                end
                else
                begin
                    push           = 1'b1;
                    push_cmd.op    = CMD_PAYLOAD;
                    push_cmd.data  = image.image_byte;
                    push_cmd.len   = LEN_W'(blk_len);
                    push_cmd.open  = blk_open;
                    push_cmd.close = (br_base == BR_W'(1));
                    push_cmd.fin   = (pr_reg == 16'd1);
                    br_next        = br_base - 1'b1;
                    pr_next        = pr_reg - 16'd1;
                    finished_next  = (pr_reg == 16'd1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg <= '0;
            hdr_cnt_reg      <= '0;
            pr_reg           <= '0;
            br_reg           <= '0;
            finished_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                image_length_reg <= cfg_data;
            hdr_cnt_reg  <= hdr_cnt_next;
            pr_reg       <= pr_next;
            br_reg       <= br_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hs_we)
            hs_reg[hs_idx] <= image.image_byte;
    end

    a_idle_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !image.starts_image && finished_reg) |-> !push)
        else $error("command issued for a byte after the image end");

    a_short_done: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_cmd.op == CMD_SHORT) |=> finished_reg)
        else $error("short image did not finish");

    a_header_done: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_cmd.op == CMD_HEADER) |=> (hdr_cnt_reg == HDR_CNT_W'(HEADER_BYTES)))
        else $error("header burst issued before the header was complete");

endmodule

[rtl/core/rkf_queue.sv]
// ----------------------------------------------------------------------------
// rkf_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module rkf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rkf_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          q_full,
    output logic          q_valid,
    output rkf_pkg::cmd_t head
);
    import rkf_pkg::*;

    cmd_t              entry_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from an empty queue");

endmodule

[rtl/core/rkf_back.sv]
// ----------------------------------------------------------------------------
// rkf_back
// expands queued commands into host bytes, one per cycle while the host is ready
// ----------------------------------------------------------------------------
module rkf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  rkf_pkg::cmd_t head,
    output logic          pop,
    rkf_out_if.source     host
);
    import rkf_pkg::*;

    logic [SLOTS-1:0]  done_reg, done_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [1:0]        byte_kind_reg;
    logic              last_reg;

    logic [SLOTS-1:0]  mask, pending, cur_bit;
    logic [SLOT_W-1:0] cur_idx;
    logic              last;
    logic              load;
    logic [7:0]        slot_byte [0:SLOTS-1];
    logic [1:0]        slot_kind [0:SLOTS-1];

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_byte[i] = BYTE_BLOCK_END;
            slot_kind[i] = KIND_FRAME;
        end
        mask = '0;
        unique case (head.op)
            CMD_SHORT:
            begin
                mask         = 6'b000001;
                slot_byte[0] = BYTE_STATUS_SHORT;
                slot_kind[0] = KIND_STATUS;
            end
            CMD_HEADER:
            begin
                mask         = {1'b0, head.fin, 4'b1111};
                slot_byte[0] = BYTE_HEADER_TAG;
                slot_byte[1] = head.data;
                slot_byte[2] = head.aux;
                slot_byte[3] = BYTE_BLOCK_END;
                slot_byte[4] = BYTE_STATUS_OK;
                slot_kind[4] = KIND_STATUS;
            end
            CMD_PAYLOAD:
            begin
                mask         = {head.fin, head.close, 1'b1, head.open, head.open, head.open};
                slot_byte[0] = BYTE_BLOCK_OPEN;
                slot_byte[1] = head.len[7:0];
                slot_byte[2] = 8'(head.len[LEN_W-1:8]);
                slot_byte[3] = head.data;
                slot_kind[3] = KIND_DATA;
                slot_byte[4] = BYTE_BLOCK_END;
                slot_byte[5] = BYTE_STATUS_OK;
                slot_kind[5] = KIND_STATUS;
            end
            default:
            begin
                mask = 6'b000001;
            end
        endcase
    end

    assign pending = mask & ~done_reg;

    always_comb
    begin
        cur_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (pending[i])
                cur_idx = SLOT_W'(i);
        end
    end

    assign cur_bit = SLOTS'(1) << cur_idx;
    assign last    = ((pending & ~cur_bit) == '0);
    assign load    = q_valid && (!out_valid_reg || host.ready);
    assign pop     = load && last;

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !host.ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            done_next      = last ? '0 : (done_reg | cur_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= slot_byte[cur_idx];
            byte_kind_reg <= slot_kind[cur_idx];
            last_reg      <= last;
        end
    end

    assign host.valid       = out_valid_reg;
    assign host.out_byte    = out_byte_reg;
    assign host.byte_kind   = byte_kind_reg;
    assign host.last_of_run = last_reg;

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (host.valid && host.last_of_run))
        else $error("command retired without a last byte");

    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> ((done_reg & ~mask) == '0))
        else $error("slot tracking out of step with the head command");

endmodule

[rtl/core/rk_image_block_framer_top.sv]
// ----------------------------------------------------------------------------
// rk_image_block_framer_top
// frames a cassette-style image byte stream into host bytes
// ----------------------------------------------------------------------------
// image: request channel carrying one image byte and a start flag per
//   request; a set start flag begins a new image with that byte.
// host: request channel carrying one output byte, its kind and a flag on
//   the last byte caused by an image request.
// cfg_we / cfg_data: writes image_length; write only while idle.
// the front accepts one image request per cycle while its 4-entry command
// queue has room; requests that cause no byte take no queue entry.
// the back drains one host byte per cycle from its output register while
// the host is ready; an image request causes 0 to 6 host bytes: a payload
// byte inside an open block causes one, a block boundary up to 6.
// an accepted request's command is registered in the queue, then its first host byte in the output register.
// a host stall holds the output register; the queue then fills and the
// image channel drops ready.
// reset empties the queue and leaves the block idle until a start request;
// image_length resets to 0.
// ----------------------------------------------------------------------------
module rk_image_block_framer_top #(
    parameter int BLOCK_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    rkf_in_if.sink      image,
    rkf_out_if.source   host
);
    import rkf_pkg::*;

    logic push, pop, q_full, q_valid;
    cmd_t push_cmd, head;

    rkf_front #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .image    (image),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    rkf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .head     (head)
    );

    rkf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .host    (host)
    );

endmodule
